/* hdl/u8d_pkg.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared types and constants for the UTF-8 code point decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CodeW = 21;
  localparam int unsigned KindW = 2;
  localparam int unsigned RemW  = 2;

  // Lead byte class limits and payload masks.
  localparam logic [ByteW-1:0] LeadOneLimit   = 8'h80;
  localparam logic [ByteW-1:0] LeadTwoMax     = 8'hdf;
  localparam logic [ByteW-1:0] LeadThreeMax   = 8'hef;
  localparam logic [ByteW-1:0] LeadFourMax    = 8'hf7;
  localparam logic [ByteW-1:0] MaskOne        = 8'h7f;
  localparam logic [ByteW-1:0] MaskTwo        = 8'h1f;
  localparam logic [ByteW-1:0] MaskThree      = 8'h0f;
  localparam logic [ByteW-1:0] MaskFour       = 8'h07;
  localparam logic [ByteW-1:0] MaskCont       = 8'h3f;
  localparam int unsigned      ContBits       = 6;

  // Continuation bytes still expected after each lead class.
  localparam logic [RemW-1:0] RemNone  = 2'd0;
  localparam logic [RemW-1:0] RemOne   = 2'd1;
  localparam logic [RemW-1:0] RemTwo   = 2'd2;
  localparam logic [RemW-1:0] RemThree = 2'd3;

  // Result kind codes.
  typedef enum logic [KindW-1:0] {
    KIND_CODE    = 2'd0,
    KIND_INVALID = 2'd1,
    KIND_TRUNC   = 2'd2
  } kind_e;

  // One input byte as held in the input register.
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             end_of_string;
  } in_item_t;

  // One decode result handed to the output register.
  typedef struct packed {
    logic             emit;
    logic [CodeW-1:0] code_point;
    kind_e            kind;
    logic             last_of_string;
  } result_t;

endpackage

/* hdl/u8d_in_reg.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder input register
// Holds one accepted byte until the decode stage consumes it.
// ----------------------------------------------------------------------------
module u8d_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  u8d_pkg::in_item_t item_i,
  input  logic              advance_i,
  output logic              valid_o,
  output u8d_pkg::in_item_t item_o
);

  logic              valid_q;
  u8d_pkg::in_item_t item_q;
  logic              take;

  // The register is free when empty or when its byte moves on this cycle.
  assign in_stall_o = valid_q & ~advance_i;
  assign take       = in_valid_i & ~in_stall_o;

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= take | (valid_q & ~advance_i);
    end
  end

  // Payload is loaded on every input transfer.
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* hdl/u8d_decode.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder core
// Sequence state and the per-byte decode logic.
// ----------------------------------------------------------------------------
module u8d_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  u8d_pkg::in_item_t item_i,
  output u8d_pkg::result_t  result_o
);

  logic [u8d_pkg::RemW-1:0]  rem_q, rem_d;
  logic [u8d_pkg::CodeW-1:0] part_q, part_d;
  logic                      err_q, err_d;

  logic [u8d_pkg::ByteW-1:0] b;
  logic                      eos;
  logic [u8d_pkg::CodeW-1:0] part_next;
  logic [u8d_pkg::RemW-1:0]  rem_next;

  assign b         = item_i.data_byte;
  assign eos       = item_i.end_of_string;
  assign part_next = {part_q[u8d_pkg::CodeW-u8d_pkg::ContBits-1:0],
                      b[u8d_pkg::ContBits-1:0]};
  assign rem_next  = rem_q - u8d_pkg::RemOne;

  // Next state and result for the byte in the input register.
  always_comb begin
    rem_d                   = rem_q;
    part_d                  = part_q;
    err_d                   = err_q;
    result_o.emit           = 1'b0;
    result_o.code_point     = '0;
    result_o.kind           = u8d_pkg::KIND_CODE;
    result_o.last_of_string = eos;

    if (err_q) begin
      // Bytes after an error are dropped until the string ends.
      if (eos) begin
        rem_d  = u8d_pkg::RemNone;
        part_d = '0;
        err_d  = 1'b0;
      end
    end else if (rem_q == u8d_pkg::RemNone) begin
      if (b < u8d_pkg::LeadOneLimit) begin
        // Single-byte character.
        result_o.emit       = 1'b1;
        result_o.code_point = u8d_pkg::CodeW'(b & u8d_pkg::MaskOne);
        if (eos) begin
          part_d = '0;
        end
      end else if (b > u8d_pkg::LeadFourMax) begin
        // Invalid lead byte.
        rem_d               = u8d_pkg::RemNone;
        part_d              = '0;
        err_d               = ~eos;
        result_o.emit       = 1'b1;
        result_o.kind       = u8d_pkg::KIND_INVALID;
      end else begin
        // Multi-byte lead.
        if (b <= u8d_pkg::LeadTwoMax) begin
          part_d = u8d_pkg::CodeW'(b & u8d_pkg::MaskTwo);
          rem_d  = u8d_pkg::RemOne;
        end else if (b <= u8d_pkg::LeadThreeMax) begin
          part_d = u8d_pkg::CodeW'(b & u8d_pkg::MaskThree);
          rem_d  = u8d_pkg::RemTwo;
        end else begin
          part_d = u8d_pkg::CodeW'(b & u8d_pkg::MaskFour);
          rem_d  = u8d_pkg::RemThree;
        end
        if (eos) begin
          rem_d                   = u8d_pkg::RemNone;
          part_d                  = '0;
          result_o.emit           = 1'b1;
          result_o.kind           = u8d_pkg::KIND_TRUNC;
          result_o.last_of_string = 1'b1;
        end
      end
    end else begin
      // Continuation byte: shift in six payload bits.
      if (rem_next == u8d_pkg::RemNone) begin
        rem_d               = u8d_pkg::RemNone;
        part_d              = '0;
        result_o.emit       = 1'b1;
        result_o.code_point = part_next;
      end else if (eos) begin
        rem_d                   = u8d_pkg::RemNone;
        part_d                  = '0;
        result_o.emit           = 1'b1;
        result_o.kind           = u8d_pkg::KIND_TRUNC;
        result_o.last_of_string = 1'b1;
      end else begin
        rem_d  = rem_next;
        part_d = part_next;
      end
    end
  end

  // State moves only when the byte leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= u8d_pkg::RemNone;
      part_q <= '0;
      err_q  <= 1'b0;
    end else if (advance_i) begin
      rem_q  <= rem_d;
      part_q <= part_d;
      err_q  <= err_d;
    end
  end

endmodule

/* hdl/u8d_out_reg.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder output register
// Holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module u8d_out_reg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      advance_i,
  input  u8d_pkg::result_t          result_i,
  output logic                      free_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [u8d_pkg::CodeW-1:0] code_point_o,
  output logic [u8d_pkg::KindW-1:0] kind_o,
  output logic                      last_of_string_o
);

  logic                      valid_q;
  logic [u8d_pkg::CodeW-1:0] code_q;
  u8d_pkg::kind_e            kind_q;
  logic                      last_q;

  // The register can take a new result when empty or when drained now.
  assign free_o = ~valid_q | ~out_stall_i;

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= result_i.emit;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (advance_i && result_i.emit) begin
      code_q <= result_i.code_point;
      kind_q <= result_i.kind;
      last_q <= result_i.last_of_string;
    end
  end

  assign out_valid_o      = valid_q;
  assign code_point_o     = code_q;
  assign kind_o           = kind_q;
  assign last_of_string_o = last_q;

endmodule

/* hdl/utf8_code_point_decoder.sv */
// ----------------------------------------------------------------------------
// UTF-8 code point decoder
// Decodes a UTF-8 byte stream into code points, one byte per cycle when not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one byte per transfer, with end_of_string_i
//   set on the last byte of a string. The output channel carries a code
//   point, or an error kind (invalid lead byte, truncated sequence) with a
//   zero code point. Continuation bytes that do not finish a sequence give no
//   result unless the string ends on them, and bytes after an error give none.
//   Both channels transfer when valid is high and stall is low.
//   Throughput: one byte per cycle while neither channel stalls, set by the
//   single decode stage between the input register and the output register.
//   A result is registered in the output register when the byte that completes
//   it leaves the input register, and transfers from there when not stalled.
//   Reset clears the sequence state and both valid flags.
//   When the receiver stalls with a result held, no byte is decoded; the
//   input register takes at most one more byte, then in_stall_o stays high
//   until the held result transfers.
// ----------------------------------------------------------------------------
module utf8_code_point_decoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [u8d_pkg::ByteW-1:0] data_byte_i,
  input  logic                      end_of_string_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [u8d_pkg::CodeW-1:0] code_point_o,
  output logic [u8d_pkg::KindW-1:0] kind_o,
  output logic                      last_of_string_o
);

  u8d_pkg::in_item_t in_item;
  u8d_pkg::in_item_t held_item;
  u8d_pkg::result_t  result;
  logic              held_valid;
  logic              out_free;
  logic              advance;

  assign in_item.data_byte     = data_byte_i;
  assign in_item.end_of_string = end_of_string_i;

  // A held byte is decoded when the output register has room.
  assign advance = held_valid & out_free;

  // Input register.
  u8d_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  // Decode stage with sequence state.
  u8d_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (held_item),
    .result_o  (result)
  );

  // Output register.
  u8d_out_reg u_out_reg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .advance_i        (advance),
    .result_i         (result),
    .free_o           (out_free),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .code_point_o     (code_point_o),
    .kind_o           (kind_o),
    .last_of_string_o (last_of_string_o)
  );

endmodule

/* tb/utf8_code_point_decoder_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 code point decoder testbench
// Streams directed and random UTF-8 strings into the decoder, predicts every
// code point and error result, and compares each output transfer with the
// oldest prediction, under three patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module utf8_code_point_decoder_tb;

  localparam int unsigned HalfPeriod  = 5;
  localparam int unsigned ResetCycles = 4;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned PhaseBytes  = 170;

  // Directed strings, each entry packed as {end_of_string, data_byte}.
  localparam int unsigned DirectedLen = 25;
  localparam logic [u8d_pkg::ByteW:0] DirectedSeq [DirectedLen] = '{
    9'h041, 9'h000, 9'h17f,                 // ASCII extremes, string end
    9'h0e2, 9'h082, 9'h1ac,                 // three-byte sequence
    9'h0f0, 9'h09f, 9'h098, 9'h180,         // four-byte sequence
    9'h0f7, 9'h0bf, 9'h0bf, 9'h0bf,         // largest four-byte lead
    9'h080, 9'h03f,                         // 0x80 as lead, unchecked prefix
    9'h0ff, 9'h041, 9'h1c3,                 // invalid lead, rest dropped
    9'h1f8,                                 // invalid lead on the last byte
    9'h1e2,                                 // string ends on a lead byte
    9'h0e2, 9'h182,                         // string ends mid-sequence
    9'h0df, 9'h1ff                          // largest two-byte lead
  };

  typedef struct packed {
    logic [u8d_pkg::CodeW-1:0] code_point;
    u8d_pkg::kind_e            kind;
    logic                      last_of_string;
  } decode_result_t;

  // Predicts decoder results from accepted bytes and checks output transfers.
  class code_point_scoreboard;
    logic [u8d_pkg::RemW-1:0]  seq_left;
    logic [u8d_pkg::CodeW-1:0] seq_bits;
    bit                        drop_rest;
    decode_result_t            expected_points[$];
    int unsigned               errors;
    int unsigned               decoded_bytes;

    function new();
      clear_seq();
      drop_rest     = 1'b0;
      errors        = 0;
      decoded_bytes = 0;
    endfunction

    function void clear_seq();
      seq_left  = u8d_pkg::RemNone;
      seq_bits  = '0;
      drop_rest = 1'b0;
    endfunction

    function void push_result(logic [u8d_pkg::CodeW-1:0] cp, u8d_pkg::kind_e k,
                              logic last);
      decode_result_t r;
      r.code_point     = cp;
      r.kind           = k;
      r.last_of_string = last;
      expected_points  = {expected_points, r};
    endfunction

    function int unsigned pending();
      return expected_points.size();
    endfunction

    // Advance the predicted sequence state by one accepted byte.
    function void note_byte(logic [u8d_pkg::ByteW-1:0] b, logic eos);
      logic [u8d_pkg::CodeW-1:0] cp;
      if (drop_rest) begin
        if (eos) clear_seq();
        return;
      end
      decoded_bytes++;
      if (seq_left == u8d_pkg::RemNone) begin
        if (b < u8d_pkg::LeadOneLimit) begin
          push_result(u8d_pkg::CodeW'(b & u8d_pkg::MaskOne), u8d_pkg::KIND_CODE, eos);
          return;
        end
        if (b <= u8d_pkg::LeadTwoMax) begin
          seq_bits = u8d_pkg::CodeW'(b & u8d_pkg::MaskTwo);
          seq_left = u8d_pkg::RemOne;
        end else if (b <= u8d_pkg::LeadThreeMax) begin
          seq_bits = u8d_pkg::CodeW'(b & u8d_pkg::MaskThree);
          seq_left = u8d_pkg::RemTwo;
        end else if (b <= u8d_pkg::LeadFourMax) begin
          seq_bits = u8d_pkg::CodeW'(b & u8d_pkg::MaskFour);
          seq_left = u8d_pkg::RemThree;
        end else begin
          clear_seq();
          drop_rest = !eos;
          push_result('0, u8d_pkg::KIND_INVALID, eos);
          return;
        end
        if (eos) begin
          clear_seq();
          push_result('0, u8d_pkg::KIND_TRUNC, 1'b1);
        end
        return;
      end
      // Continuation byte: shift in its low six bits.
      seq_bits = (seq_bits << u8d_pkg::ContBits) |
                 u8d_pkg::CodeW'(b & u8d_pkg::MaskCont);
      seq_left = seq_left - 1'b1;
      if (seq_left == u8d_pkg::RemNone) begin
        cp = seq_bits;
        clear_seq();
        push_result(cp, u8d_pkg::KIND_CODE, eos);
      end else if (eos) begin
        clear_seq();
        push_result('0, u8d_pkg::KIND_TRUNC, 1'b1);
      end
    endfunction

    // Compare one output transfer with the oldest prediction.
    function void check_result(logic [u8d_pkg::CodeW-1:0] cp,
                               logic [u8d_pkg::KindW-1:0] k, logic last);
      decode_result_t r;
      if (expected_points.size() == 0) begin
        $error("unexpected result: code_point %0h kind %0d last_of_string %0b",
               cp, k, last);
        errors++;
        return;
      end
      r = expected_points.pop_front();
      if (cp !== r.code_point) begin
        $error("code_point mismatch: expected %0h, actual %0h", r.code_point, cp);
        errors++;
      end
      if (k !== r.kind) begin
        $error("kind mismatch: expected %0d, actual %0d", r.kind, k);
        errors++;
      end
      if (last !== r.last_of_string) begin
        $error("last_of_string mismatch: expected %0b, actual %0b",
               r.last_of_string, last);
        errors++;
      end
    endfunction
  endclass

  logic                      clk_i            = 1'b0;
  logic                      rst_ni           = 1'b0;
  logic                      in_valid_i       = 1'b0;
  logic                      in_stall_o;
  logic [u8d_pkg::ByteW-1:0] data_byte_i      = '0;
  logic                      end_of_string_i  = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i      = 1'b0;
  logic [u8d_pkg::CodeW-1:0] code_point_o;
  logic [u8d_pkg::KindW-1:0] kind_o;
  logic                      last_of_string_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles  = 0;
  code_point_scoreboard sb = new();

  utf8_code_point_decoder uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .end_of_string_i  (end_of_string_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .code_point_o     (code_point_o),
    .kind_o           (kind_o),
    .last_of_string_o (last_of_string_o)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // The receiver stalls at random, at the rate of the current phase.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Record every transfer on both channels and watch for a hang.
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) sb.note_byte(data_byte_i, end_of_string_i);
    if (out_valid_o && !out_stall_i) sb.check_result(code_point_o, kind_o, last_of_string_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one byte, with random idle cycles ahead of it, until it transfers.
  task automatic send_byte(input logic [u8d_pkg::ByteW-1:0] b, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    end_of_string_i <= eos;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Send a string of mostly well-formed sequences, with some noise bytes
  // and some strings cut short.
  task automatic send_random_string();
    logic [u8d_pkg::ByteW-1:0] str_q[$];
    int unsigned               n_points;
    int unsigned               n_cont;
    n_points = $urandom_range(1, 5);
    for (int p = 0; p < n_points; p++) begin
      n_cont = $urandom_range(3);
      case (n_cont)
        0: str_q = {str_q, u8d_pkg::ByteW'($urandom_range(8'h7f))};
        1: str_q = {str_q, u8d_pkg::ByteW'($urandom_range(8'hc0, 8'hdf))};
        2: str_q = {str_q, u8d_pkg::ByteW'($urandom_range(8'he0, 8'hef))};
        default: str_q = {str_q, u8d_pkg::ByteW'($urandom_range(8'hf0, 8'hf7))};
      endcase
      for (int c = 0; c < n_cont; c++) begin
        if ($urandom_range(7) == 0) begin
          str_q = {str_q, u8d_pkg::ByteW'($urandom_range(8'hff))};
        end else begin
          str_q = {str_q, 8'h80 | u8d_pkg::ByteW'($urandom_range(8'h3f))};
        end
      end
    end
    // Noise: overwrite one byte, often with an invalid lead byte.
    if ($urandom_range(9) == 0) begin
      str_q[$urandom_range(str_q.size() - 1)] = ($urandom_range(1) == 0) ?
          u8d_pkg::ByteW'($urandom_range(8'hf8, 8'hff)) :
          u8d_pkg::ByteW'($urandom_range(8'hff));
    end
    // Broken string: cut it off at a random point.
    if ($urandom_range(9) == 0 && str_q.size() > 1) begin
      str_q = str_q[0:$urandom_range(str_q.size() - 2)];
    end
    foreach (str_q[i]) send_byte(str_q[i], i == str_q.size() - 1);
  endtask

  // Reset, directed strings, then three random phases.
  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 19;
    recv_idle_pct = 75;
    foreach (DirectedSeq[i]) begin
      send_byte(DirectedSeq[i][u8d_pkg::ByteW-1:0], DirectedSeq[i][u8d_pkg::ByteW]);
    end
    while (sb.decoded_bytes < PhaseBytes) send_random_string();

    send_idle_pct = 75;
    recv_idle_pct = 19;
    while (sb.decoded_bytes < 2 * PhaseBytes) send_random_string();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (sb.decoded_bytes < 3 * PhaseBytes) send_random_string();
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
